[hdl/silu_pkg.sv]
// Shared constants and the sigmoid knot table for the SiLU activation block.
package silu_pkg;

    localparam int FRAC_BITS = 12;
    localparam int SEGMENTS  = 32;
    localparam int SEG_BITS  = 5;

    localparam int DATA_W = 16;
    // Magnitude of a 16-bit signed value needs one extra bit for the most negative code.
    localparam int MAG_W  = DATA_W + 1;
    // Fraction bits of the magnitude that fall inside one segment.
    localparam int SEG_SHIFT = FRAC_BITS + 3 - SEG_BITS;
    localparam int IDX_W  = MAG_W - SEG_SHIFT;
    localparam int ROM_AW = SEG_BITS + 1;
    localparam int SIG_W  = 17;
    localparam int KNOT_W = 16;

    localparam logic [SIG_W-1:0] SIG_ONE = SIG_W'(65536);

    typedef logic [SIG_W-1:0]  sig_t;
    typedef logic [KNOT_W-1:0] knot_t;

    // Sigmoid at knot k, that is at |x| = 8*k/SEGMENTS, unsigned Q0.16.
    function automatic knot_t sig_knot(input logic [ROM_AW-1:0] k);
        knot_t v;
        case (k)
            6'd0:    v = 16'd32768;
            6'd1:    v = 16'd36843;
            6'd2:    v = 16'd40793;
            6'd3:    v = 16'd44511;
            6'd4:    v = 16'd47911;
            6'd5:    v = 16'd50941;
            6'd6:    v = 16'd53581;
            6'd7:    v = 16'd55834;
            6'd8:    v = 16'd57724;
            6'd9:    v = 16'd59287;
            6'd10:   v = 16'd60565;
            6'd11:   v = 16'd61598;
            6'd12:   v = 16'd62428;
            6'd13:   v = 16'd63090;
            6'd14:   v = 16'd63615;
            6'd15:   v = 16'd64030;
            6'd16:   v = 16'd64357;
            6'd17:   v = 16'd64614;
            6'd18:   v = 16'd64816;
            6'd19:   v = 16'd64974;
            6'd20:   v = 16'd65097;
            6'd21:   v = 16'd65194;
            6'd22:   v = 16'd65269;
            6'd23:   v = 16'd65328;
            6'd24:   v = 16'd65374;
            6'd25:   v = 16'd65410;
            6'd26:   v = 16'd65438;
            6'd27:   v = 16'd65459;
            6'd28:   v = 16'd65476;
            6'd29:   v = 16'd65489;
            6'd30:   v = 16'd65500;
            6'd31:   v = 16'd65508;
            6'd32:   v = 16'd65514;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/silu_sigmoid.sv]
// Three-stage sigmoid of a signed Q3.12 value by linear interpolation between table knots.
module silu_sigmoid
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [silu_pkg::DATA_W-1:0]   x,
    output silu_pkg::sig_t                s
);

    localparam int PROD_W = silu_pkg::KNOT_W + silu_pkg::SEG_SHIFT;

    logic signed [silu_pkg::MAG_W-1:0]  x_ext;
    logic [silu_pkg::MAG_W-1:0]         mag;
    logic [silu_pkg::IDX_W-1:0]         idx;
    logic [silu_pkg::ROM_AW-1:0]        lo_k;
    logic [silu_pkg::ROM_AW-1:0]        hi_k;
    silu_pkg::knot_t                    lo_c;
    silu_pkg::knot_t                    hi_c;

    // Stage A: knot values and position inside the segment.
    silu_pkg::knot_t                    lo_a_reg;
    silu_pkg::knot_t                    diff_a_reg;
    logic [silu_pkg::SEG_SHIFT-1:0]     frac_a_reg;
    logic                               sat_a_reg;
    logic                               neg_a_reg;

    // Stage B: slope times position.
    silu_pkg::knot_t                    lo_b_reg;
    logic [PROD_W-1:0]                  mul_b_reg;
    logic                               sat_b_reg;
    logic                               neg_b_reg;

    // Stage C: finished sigmoid.
    silu_pkg::sig_t                     s_reg;
    silu_pkg::sig_t                     s_next;
    silu_pkg::sig_t                     s_mag;
    logic [PROD_W-1:0]                  mul_rnd;

    assign x_ext = $signed({x[silu_pkg::DATA_W-1], x});
    assign mag   = x[silu_pkg::DATA_W-1] ? $unsigned(-x_ext) : $unsigned(x_ext);
    assign idx   = mag[silu_pkg::MAG_W-1:silu_pkg::SEG_SHIFT];
    assign lo_k  = idx[silu_pkg::ROM_AW-1:0];
    assign hi_k  = lo_k + silu_pkg::ROM_AW'(1);
    assign lo_c  = silu_pkg::sig_knot(lo_k);
    assign hi_c  = silu_pkg::sig_knot(hi_k);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_a_reg   <= lo_c;
            diff_a_reg <= (hi_c > lo_c) ? hi_c - lo_c : '0;
            frac_a_reg <= mag[silu_pkg::SEG_SHIFT-1:0];
            sat_a_reg  <= (idx >= silu_pkg::IDX_W'(silu_pkg::SEGMENTS));
            neg_a_reg  <= x[silu_pkg::DATA_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_b_reg  <= lo_a_reg;
            mul_b_reg <= PROD_W'(diff_a_reg) * PROD_W'(frac_a_reg);
            sat_b_reg <= sat_a_reg;
            neg_b_reg <= neg_a_reg;
        end
    end

    // Round half up when dropping the segment position bits.
    assign mul_rnd = mul_b_reg + PROD_W'(1 << (silu_pkg::SEG_SHIFT - 1));

    always_comb
    begin
        if (sat_b_reg)
        begin
            s_mag = silu_pkg::SIG_ONE;
        end
        else
        begin
            s_mag = silu_pkg::SIG_W'(lo_b_reg)
                  + silu_pkg::SIG_W'(mul_rnd[PROD_W-1:silu_pkg::SEG_SHIFT]);
        end
        // sigmoid(-a) = 1 - sigmoid(a)
        s_next = neg_b_reg ? silu_pkg::SIG_ONE - s_mag : s_mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_next;
        end
    end

    assign s = s_reg;

endmodule

[hdl/silu_activation.sv]
// SiLU activation y = x * sigmoid(x) on a stream of signed Q3.12 elements.
//
// Input channel s_*: one item per element; s_tdata carries x_value, s_tlast marks
// the final element of a tensor. Output channel m_*: one item per input item, in
// order; m_tdata carries y_value (rounded half up, saturated), m_tlast copies the
// input flag.
// The datapath is a five-stage pipeline: knot lookup, slope multiply, sigmoid
// assembly, x times sigmoid, then rounding and saturation into the output register.
// Throughput is one item per cycle while m_tready stays high.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is dropped or duplicated, and an item
// is taken again as soon as m_tready returns.
// Reset (rst_n low) empties the pipeline: m_tvalid and every valid bit go low; data
// registers are not reset. No configuration is needed; the sigmoid table is constant.
module silu_activation
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] x_value
    input  logic        s_tlast,    // last_in

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] y_value
    output logic        m_tlast     // last_out
);

    localparam int DEPTH  = 3;
    localparam int MULT_W = silu_pkg::DATA_W + silu_pkg::SIG_W + 1;
    localparam int RND_W  = MULT_W - 16;

    logic                                      en;
    silu_pkg::sig_t                            sig;

    logic [DEPTH-1:0]                          v_pipe_reg;
    logic [DEPTH-1:0]                          last_pipe_reg;
    logic signed [silu_pkg::DATA_W-1:0]        x_pipe_reg [DEPTH];

    logic                                      v_mul_reg;
    logic                                      last_mul_reg;
    logic signed [MULT_W-1:0]                  prod_reg;

    logic signed [MULT_W-1:0]                  prod_rnd;
    logic signed [RND_W-1:0]                   y_wide;
    logic signed [silu_pkg::DATA_W-1:0]        y_next;

    logic                                      out_valid_reg;
    logic                                      out_last_reg;
    logic signed [silu_pkg::DATA_W-1:0]        out_data_reg;

    // The pipeline moves as one whenever the output slot is free or being taken.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    silu_sigmoid u_sigmoid
    (
        .clk (clk),
        .en  (en),
        .x   (s_tdata),
        .s   (sig)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_pipe_reg    <= '0;
            v_mul_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_pipe_reg    <= {v_pipe_reg[DEPTH-2:0], s_tvalid};
            v_mul_reg     <= v_pipe_reg[DEPTH-1];
            out_valid_reg <= v_mul_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_pipe_reg <= {last_pipe_reg[DEPTH-2:0], s_tlast};
            x_pipe_reg[0] <= $signed(s_tdata);
            for (int i = 1; i < DEPTH; i++)
            begin
                x_pipe_reg[i] <= x_pipe_reg[i-1];
            end
            last_mul_reg  <= last_pipe_reg[DEPTH-1];
            prod_reg      <= MULT_W'(x_pipe_reg[DEPTH-1]) * $signed(MULT_W'(sig));
            out_last_reg  <= last_mul_reg;
            out_data_reg  <= y_next;
        end
    end

    // Round half up at 16 sigmoid fraction bits, then clamp to 16 bits.
    assign prod_rnd = prod_reg + MULT_W'(32768);
    assign y_wide   = prod_rnd[MULT_W-1:16];

    always_comb
    begin
        if (y_wide > RND_W'(32767))
        begin
            y_next = 16'sh7FFF;
        end
        else if (y_wide < -RND_W'(32768))
        begin
            y_next = -16'sh8000;
        end
        else
        begin
            y_next = y_wide[silu_pkg::DATA_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (out_valid_reg == $past(v_mul_reg)) && (v_mul_reg == $past(v_pipe_reg[DEPTH-1])))
        else $error("valid bit lost or invented in the pipeline");
`endif

`ifndef ASSERT_OFF
    a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_pipe_reg[DEPTH-1] |-> (sig <= silu_pkg::SIG_ONE))
        else $error("sigmoid above one");
`endif

`ifndef ASSERT_OFF
    a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v_pipe_reg[DEPTH-1] && !x_pipe_reg[DEPTH-1][silu_pkg::DATA_W-1])
        |=> !prod_reg[MULT_W-1])
        else $error("non-negative input gave negative product");
`endif

`ifndef ASSERT_OFF
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(prod_reg) && $stable(v_pipe_reg) && $stable(sig))
        else $error("pipeline moved during a stall");
`endif

endmodule

[tb/silu_activation_tb.sv]
// Self-checking stream testbench for the SiLU activation block with a scoreboard class.
`timescale 1ns / 1ps

typedef struct packed {
    logic [15:0] y_value;
    logic        last;
} silu_result_t;

class swish_checker;
    localparam int  KNOTS     = 32;
    localparam int  FRAC      = 12;
    localparam int  MAX_PRINT = 20;
    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint unsigned ONE16 = 64'd65536;

    longint unsigned knot[0:KNOTS];
    silu_result_t    expected_y[$];
    int              errors;
    int              checked;
    int              lasts_seen;

    function new();
        longint unsigned v, e, term, d;
        longint          sum;
        int              k, n;
        errors     = 0;
        checked    = 0;
        lasts_seen = 0;
        // Sigmoid at each knot t = 8k/KNOTS: e^-t is built as (e^(-t/16))^16.
        for (k = 0; k <= KNOTS; k++)
        begin
            v    = ((longint'(k) << 30) + KNOTS) / (2 * KNOTS);
            sum  = longint'(Q30);
            term = Q30;
            for (n = 1; n <= 14; n++)
            begin
                term = ((term * v) >> 30) / longint'(n);
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            e = longint'(sum);
            for (n = 0; n < 4; n++)
                e = (e * e + (Q30 >> 1)) >> 30;
            d = Q30 + e;
            knot[k] = ((64'd1 << 46) + (d >> 1)) / d;
        end
    endfunction

    // Sigmoid of a magnitude in Q.FRAC, result in Q0.16.
    function longint unsigned sigmoid_of_mag(longint unsigned a);
        longint unsigned span, num, idx, rem, lo, hi;
        span = 64'd8 << FRAC;
        num  = a * KNOTS;
        idx  = num / span;
        rem  = num % span;
        if (idx >= KNOTS)
            return ONE16;
        lo = knot[idx];
        hi = knot[idx + 1];
        if (hi < lo)
            hi = lo;
        return lo + ((hi - lo) * rem + span / 2) / span;
    endfunction

    function logic [15:0] predict_swish(logic signed [15:0] x);
        longint          xi, prod, y;
        longint unsigned s;
        xi = longint'(x);
        s  = sigmoid_of_mag((xi < 0) ? longint'(-xi) : longint'(xi));
        if (xi < 0)
            s = ONE16 - s;
        prod = xi * longint'(s);
        // Floor of (prod + half) is round half up.
        y = (prod + 32768) >>> 16;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        return y[15:0];
    endfunction

    function void note_element(logic [15:0] x, logic last);
        silu_result_t r;
        r.y_value = predict_swish(x);
        r.last    = last;
        expected_y.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINT)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     checked, what, got, want);
    endtask

    task check_element(logic [15:0] y, logic last);
        silu_result_t r;
        if (expected_y.size() == 0)
        begin
            report_mismatch("unexpected result, y_value", int'($signed(y)), 0);
            return;
        end
        r = expected_y.pop_front();
        if (y !== r.y_value)
            report_mismatch("y_value", int'($signed(y)), int'($signed(r.y_value)));
        if (last !== r.last)
            report_mismatch("last_out", int'(last), int'(r.last));
        if (last === 1'b1)
            lasts_seen++;
        checked++;
    endtask

    function int pending();
        return expected_y.size();
    endfunction
endclass

module silu_activation_tb;

    localparam int  RESET_CYCLES  = 11;
    localparam int  RANDOM_ITEMS  = 580;
    localparam int  HOLD_AT       = 150;
    localparam int  HOLD_CYCLES   = 80;
    localparam int  DRAIN_CYCLES  = 20;
    localparam longint CYCLE_LIMIT = 200000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    swish_checker sb;
    longint       cycles = 0;
    int           sent   = 0;
    int           taken  = 0;

    silu_activation dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Every fourth stretch of fifty items runs with no idle cycles at all.
    function automatic int idle_cycles(int n);
        if ((n / 50) % 4 == 3)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(logic [15:0] x, logic last);
        int gap;
        gap = idle_cycles(sent);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        sb.note_element(x, last);
        sent++;
        @(negedge clk);
    endtask

    // Values around a segment boundary, either sign.
    function automatic logic [15:0] near_knot();
        int v;
        v = $urandom_range(0, 32) * 1024 + $urandom_range(0, 2) - 1;
        if (v > 32767)
            v = 32767;
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v[15:0];
    endfunction

    function automatic logic [15:0] random_x();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 8191) - 4096);
            1:       return near_knot();
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int steps;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            steps = (taken == HOLD_AT) ? HOLD_CYCLES : idle_cycles(taken);
            if (steps > 0)
            begin
                m_tready <= 1'b0;
                repeat (steps) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            sb.check_element(m_tdata, m_tlast);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        logic [15:0] directed[$];
        int          len, i, k;
        logic        broken;
        sb = new();
        directed = {16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
                    16'h7FFE, 16'h1000, 16'hF000, 16'h0400, 16'hFC00, 16'h03FF,
                    16'hFC01, 16'h0800, 16'hF800, 16'h4000, 16'hC000, 16'h7C00,
                    16'h83FF, 16'h5555, 16'hAAAA, 16'h0401, 16'h2000, 16'hE000};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes, zero, unit values and segment edges; last set every few items.
        for (i = 0; i < directed.size(); i++)
            send_item(directed[i], (i % 6 == 5) || (i == directed.size() - 1));

        // Mostly tensors with the flag on the final element; some have it scattered.
        while (sent < directed.size() + RANDOM_ITEMS)
        begin
            len    = $urandom_range(1, 40);
            broken = ($urandom_range(0, 7) == 0);
            for (k = 0; k < len; k++)
            begin
                if (broken)
                    send_item(random_x(), $urandom_range(0, 3) == 0);
                else
                    send_item(random_x(), k == len - 1);
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d elements in, %0d results checked, %0d carried the last flag",
                 sent, sb.checked, sb.lasts_seen);
        $display("summary: directed extremes and segment edges, random tensors, one long output stall");
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[silu_activation.f]
hdl/silu_pkg.sv
hdl/silu_sigmoid.sv
hdl/silu_activation.sv
tb/silu_activation_tb.sv
